// ----- sv/sfwdf_pkg.sv -----
// Shared types, constants and helper functions for the signed fixed-width
// decimal formatter. No dependencies; imported by every other file.
package sfwdf_pkg;

    // Default largest digit field
    localparam int MAX_WIDTH_DEF = 9;

    // Field widths
    localparam int VAL_W      = 32;
    localparam int FLD_W      = 4;
    localparam int CHAR_W     = 8;
    localparam int IN_TDATA_W = 48;

    // Remainder width: a value that fits the field is below 10^9 < 2^30
    localparam int REM_W = 30;

    // Divide by ten as multiply by reciprocal, then shift
    localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;
    localparam int          PROD_W      = REM_W + 32;
    localparam int          QUO_W       = PROD_W - RECIP_SHIFT;

    // ASCII codes
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;

    // Per-word controls carried down the pipeline
    typedef struct packed {
        logic             neg;
        logic [FLD_W-1:0] w;
        logic [FLD_W-1:0] k;
        logic             zp;
        logic             bad;
        logic             ovf;
    } t_ctrl;

    // Field limit 10^n
    function automatic logic [VAL_W-1:0] pow10(input logic [FLD_W-1:0] n);
        logic [VAL_W-1:0] r;
        case (n)
            4'd0:    r = 32'd1;
            4'd1:    r = 32'd10;
            4'd2:    r = 32'd100;
            4'd3:    r = 32'd1000;
            4'd4:    r = 32'd10000;
            4'd5:    r = 32'd100000;
            4'd6:    r = 32'd1000000;
            4'd7:    r = 32'd10000000;
            4'd8:    r = 32'd100000000;
            4'd9:    r = 32'd1000000000;
            default: r = 32'hFFFF_FFFF;
        endcase
        return r;
    endfunction

endpackage

// ----- sv/signed_fixed_width_decimal_formatter.sv -----
// Top level of the signed fixed-width decimal formatter: front stage, a chain
// of digit stages and the serialiser. Depends on sfwdf_pkg and its submodules.

// Each input word (a signed 32-bit value, field width, fraction digit count and
// zero-pad flag) becomes an ASCII string sent one character per output word,
// left to right, with tlast on its final character: a sign character, then
// width digit positions with a '.' before the fraction digits. An out-of-range
// width gives a single '-'; a value that does not fit gives '-' and width-1 'x'.
// Input words pass a front stage, MAX_WIDTH divide-by-ten stages (one
// reciprocal multiplier each), the serialiser's word holder and its output
// register before the first character is offered. A string has 1 to
// MAX_WIDTH+2 characters (eleven at most for the default), and the output port
// at one character per cycle, while the receiver does not stall it, sets the
// sustained rate; the next string follows its predecessor without a gap.
module signed_fixed_width_decimal_formatter #(
    parameter int MAX_WIDTH = sfwdf_pkg::MAX_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [31:0] value, [35:32] width, [39:36] frac_digits, [40] zero_pad, rest zero
    input  logic [sfwdf_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [7:0] out_char
    output logic [sfwdf_pkg::CHAR_W-1:0]       o_m_axis_tdata,
    output logic                               o_m_axis_tlast
);
    import sfwdf_pkg::*;

    // Stage links: index 0 leaves the front, index i+1 leaves digit stage i
    logic                       w_v     [0:MAX_WIDTH];
    logic                       w_rdy   [0:MAX_WIDTH];
    t_ctrl                      w_ctrl  [0:MAX_WIDTH];
    logic [REM_W-1:0]           w_rem   [0:MAX_WIDTH];
    logic [MAX_WIDTH-1:0][3:0]  w_dig   [0:MAX_WIDTH];
    logic [MAX_WIDTH-1:0]       w_shown [0:MAX_WIDTH];

    sfwdf_front #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_value      (i_s_axis_tdata[31:0]),
        .i_width      (i_s_axis_tdata[35:32]),
        .i_frac_digits(i_s_axis_tdata[39:36]),
        .i_zero_pad   (i_s_axis_tdata[40]),
        .o_valid      (w_v[0]),
        .i_ready      (w_rdy[0]),
        .o_ctrl       (w_ctrl[0]),
        .o_rem        (w_rem[0])
    );

    // Digit arrays start empty; each stage fills its own position
    assign w_dig[0]   = '0;
    assign w_shown[0] = '0;

    for (genvar gi = 0; gi < MAX_WIDTH; gi++) begin : g_digit
        sfwdf_digit #(
            .MAX_WIDTH(MAX_WIDTH),
            .IDX      (gi)
        ) u_digit (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_valid(w_v[gi]),
            .o_ready(w_rdy[gi]),
            .i_ctrl (w_ctrl[gi]),
            .i_rem  (w_rem[gi]),
            .i_dig  (w_dig[gi]),
            .i_shown(w_shown[gi]),
            .o_valid(w_v[gi+1]),
            .i_ready(w_rdy[gi+1]),
            .o_ctrl (w_ctrl[gi+1]),
            .o_rem  (w_rem[gi+1]),
            .o_dig  (w_dig[gi+1]),
            .o_shown(w_shown[gi+1])
        );
    end

    sfwdf_ser #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_ser (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(w_v[MAX_WIDTH]),
        .o_ready(w_rdy[MAX_WIDTH]),
        .i_ctrl (w_ctrl[MAX_WIDTH]),
        .i_dig  (w_dig[MAX_WIDTH]),
        .i_shown(w_shown[MAX_WIDTH]),
        .o_valid(o_m_axis_tvalid),
        .i_ready(i_m_axis_tready),
        .o_char (o_m_axis_tdata),
        .o_last (o_m_axis_tlast)
    );

`ifndef SYNTHESIS
    // Output is idle the cycle after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output word valid right after reset");

    // A string never ends in padding space or in the point
    a_last_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |->
            (o_m_axis_tdata != CH_SPACE && o_m_axis_tdata != CH_DOT))
        else $error("string ends in space or point");

    // Input back-pressure only while the front stage holds a word
    a_front_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (w_v[0] && !w_rdy[0]))
        else $error("input stalled with front stage free");
`endif

endmodule

// ----- sv/sfwdf_front.sv -----
// Front stage: unpacks the input word, takes the magnitude and decides the
// out-of-range and overflow cases. Depends on sfwdf_pkg.
module sfwdf_front #(
    parameter int MAX_WIDTH = sfwdf_pkg::MAX_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [sfwdf_pkg::VAL_W-1:0]  i_value,
    input  logic [sfwdf_pkg::FLD_W-1:0]  i_width,
    input  logic [sfwdf_pkg::FLD_W-1:0]  i_frac_digits,
    input  logic                         i_zero_pad,
    output logic                         o_valid,
    input  logic                         i_ready,
    output sfwdf_pkg::t_ctrl             o_ctrl,
    output logic [sfwdf_pkg::REM_W-1:0]  o_rem
);
    import sfwdf_pkg::*;

    logic             r_v;
    t_ctrl            r_ctrl;
    logic [REM_W-1:0] r_rem;
    t_ctrl            n_ctrl;
    logic [VAL_W-1:0] n_mag;

    assign o_ready = !r_v || i_ready;

    // Magnitude and range decisions
    always_comb begin
        n_ctrl.neg = i_value[VAL_W-1];
        n_mag      = n_ctrl.neg ? (VAL_W'(0) - i_value) : i_value;
        n_ctrl.w   = i_width;
        n_ctrl.k   = i_frac_digits;
        n_ctrl.zp  = i_zero_pad;
        n_ctrl.bad = (i_width == '0) || (i_width > FLD_W'(MAX_WIDTH));
        n_ctrl.ovf = (n_mag >= pow10(i_width)) || (i_frac_digits > i_width);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_ctrl <= n_ctrl;
            r_rem  <= n_mag[REM_W-1:0];
        end
    end

    assign o_valid = r_v;
    assign o_ctrl  = r_ctrl;
    assign o_rem   = r_rem;

endmodule

// ----- sv/sfwdf_digit.sv -----
// One digit stage: divides the running remainder by ten and records the
// digit and its shown flag at position IDX. Depends on sfwdf_pkg.
module sfwdf_digit #(
    parameter int MAX_WIDTH = sfwdf_pkg::MAX_WIDTH_DEF,
    parameter int IDX       = 0
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  sfwdf_pkg::t_ctrl                     i_ctrl,
    input  logic [sfwdf_pkg::REM_W-1:0]          i_rem,
    input  logic [MAX_WIDTH-1:0][3:0]            i_dig,
    input  logic [MAX_WIDTH-1:0]                 i_shown,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output sfwdf_pkg::t_ctrl                     o_ctrl,
    output logic [sfwdf_pkg::REM_W-1:0]          o_rem,
    output logic [MAX_WIDTH-1:0][3:0]            o_dig,
    output logic [MAX_WIDTH-1:0]                 o_shown
);
    import sfwdf_pkg::*;

    logic                       r_v;
    t_ctrl                      r_ctrl;
    logic [REM_W-1:0]           r_rem;
    logic [MAX_WIDTH-1:0][3:0]  r_dig;
    logic [MAX_WIDTH-1:0]       r_shown;

    logic [PROD_W-1:0]          prod;
    logic [QUO_W-1:0]           quo;
    logic [REM_W-1:0]           n_rem;
    logic [REM_W-1:0]           quo10;
    logic [3:0]                 n_digit;
    logic [MAX_WIDTH-1:0][3:0]  n_dig;
    logic [MAX_WIDTH-1:0]       n_shown;

    assign o_ready = !r_v || i_ready;

    // Quotient by reciprocal multiply, digit from the remainder
    always_comb begin
        prod    = PROD_W'(i_rem) * PROD_W'(RECIP10);
        quo     = prod[PROD_W-1:RECIP_SHIFT];
        n_rem   = REM_W'(quo);
        quo10   = (n_rem << 3) + (n_rem << 1);
        n_digit = 4'(i_rem - quo10);
    end

    // Digit arrays with this stage's position filled in
    always_comb begin
        n_dig          = i_dig;
        n_dig[IDX]     = n_digit;
        n_shown        = i_shown;
        n_shown[IDX]   = (i_rem != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_ctrl  <= i_ctrl;
            r_rem   <= n_rem;
            r_dig   <= n_dig;
            r_shown <= n_shown;
        end
    end

    assign o_valid = r_v;
    assign o_ctrl  = r_ctrl;
    assign o_rem   = r_rem;
    assign o_dig   = r_dig;
    assign o_shown = r_shown;

endmodule

// ----- sv/sfwdf_ser.sv -----
// Serialiser: holds one formatted word and sends its characters left to
// right through a registered output. Depends on sfwdf_pkg.
module sfwdf_ser #(
    parameter int MAX_WIDTH = sfwdf_pkg::MAX_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  sfwdf_pkg::t_ctrl              i_ctrl,
    input  logic [MAX_WIDTH-1:0][3:0]     i_dig,
    input  logic [MAX_WIDTH-1:0]          i_shown,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [sfwdf_pkg::CHAR_W-1:0]  o_char,
    output logic                          o_last
);
    import sfwdf_pkg::*;

    localparam int PW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW = $clog2(MAX_WIDTH + 2);

    logic                       r_busy;
    logic [CW-1:0]              r_idx;
    t_ctrl                      r_ctrl;
    logic [MAX_WIDTH-1:0][3:0]  r_dig;
    logic [MAX_WIDTH-1:0]       r_shown;
    logic                       r_ov;
    logic [CHAR_W-1:0]          r_oc;
    logic                       r_ol;

    logic              adv;
    logic              take;
    logic [FLD_W-1:0]  idx4;
    logic [FLD_W-1:0]  t;
    logic [FLD_W-1:0]  int_n;
    logic [FLD_W-1:0]  pos;
    logic [PW-1:0]     psel;
    logic              is_pt;
    logic [3:0]        dsel;
    logic              ssel;
    logic [FLD_W-1:0]  last_idx;
    logic [CHAR_W-1:0] n_char;
    logic              n_last;

    // Output slot frees when empty or taken
    assign adv     = !r_ov || i_ready;
    assign o_ready = !r_busy || (adv && n_last);
    assign take    = i_valid && o_ready;

    // Character at the current index
    always_comb begin
        idx4  = FLD_W'(r_idx);
        t     = idx4 - 4'd1;
        int_n = r_ctrl.w - r_ctrl.k;
        if (t < int_n) begin
            pos = r_ctrl.w - 4'd1 - t;
        end else begin
            pos = r_ctrl.w - t;
        end
        psel  = (pos < FLD_W'(MAX_WIDTH)) ? pos[PW-1:0] : '0;
        dsel  = r_dig[psel];
        ssel  = r_shown[psel];
        is_pt = (r_ctrl.k != '0) && (t == int_n);

        if (r_ctrl.bad) begin
            n_char   = CH_MINUS;
            last_idx = '0;
        end else if (r_ctrl.ovf) begin
            n_char   = (idx4 == '0) ? CH_MINUS : CH_X;
            last_idx = r_ctrl.w - 4'd1;
        end else begin
            last_idx = r_ctrl.w + FLD_W'(r_ctrl.k != '0);
            if (idx4 == '0) begin
                n_char = r_ctrl.neg ? CH_MINUS : CH_SPACE;
            end else if (is_pt) begin
                n_char = CH_DOT;
            end else if (ssel) begin
                n_char = CH_ZERO + CHAR_W'(dsel);
            end else if ((pos <= r_ctrl.k) || r_ctrl.zp) begin
                n_char = CH_ZERO;
            end else begin
                n_char = CH_SPACE;
            end
        end
        n_last = (idx4 == last_idx);
    end

    // Word holder and index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (take) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (r_busy && adv) begin
            if (n_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_ctrl  <= i_ctrl;
            r_dig   <= i_dig;
            r_shown <= i_shown;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_busy) begin
            r_oc <= n_char;
            r_ol <= n_last;
        end
    end

    assign o_valid = r_ov;
    assign o_char  = r_oc;
    assign o_last  = r_ol;

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for signed_fixed_width_decimal_formatter.
// Depends on sfwdf_pkg and the formatter RTL. It checks every output word
// against a string predicted for each input word the block accepts.
module tb_top;
    import sfwdf_pkg::*;

    localparam int FIELD_MAX   = 9;               // MAX_WIDTH of the instance
    localparam int TAIL_CYCLES = 2 * (FIELD_MAX + 3);

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_char_exp;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  src_valid;
    logic [IN_TDATA_W-1:0] src_data;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic                  sink_ready;
    logic [CHAR_W-1:0]     o_m_axis_tdata;
    logic                  o_m_axis_tlast;

    logic [IN_TDATA_W-1:0] words_to_send [$];
    t_char_exp             pending_chars [$];
    logic                  word_taken;
    int                    send_idle_pct;
    int                    recv_stall_pct;
    int                    err_count;
    int                    values_formatted;
    int                    chars_checked;

    signed_fixed_width_decimal_formatter #(.MAX_WIDTH(FIELD_MAX)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (src_valid),
        .o_s_axis_tready (o_s_axis_tready),
        // [31:0] value, [35:32] width, [39:36] frac_digits, [40] zero_pad
        .i_s_axis_tdata  (src_data),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (sink_ready),
        // [7:0] out_char
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // Clock, period 10
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // 10^n, wide enough for any field width
    function automatic logic [63:0] ten_to(input int n);
        logic [63:0] r;
        r = 64'd1;
        for (int j = 0; j < n; j++) r = r * 64'd10;
        return r;
    endfunction

    // Work out the string for one input word and queue its characters
    function automatic void predict_string(input logic [IN_TDATA_W-1:0] word);
        logic [31:0]       value;
        logic [31:0]       mag;
        logic [31:0]       rem;
        logic              neg;
        logic              zp;
        int                w;
        int                k;
        int                digit [FIELD_MAX];
        logic              shown [FIELD_MAX];
        logic [CHAR_W-1:0] text [$];
        t_char_exp         e;
        value = word[31:0];
        w     = int'(word[35:32]);
        k     = int'(word[39:36]);
        zp    = word[40];
        neg   = value[31];
        mag   = neg ? (32'd0 - value) : value;
        if (w == 0 || w > FIELD_MAX) begin
            text.push_back(CH_MINUS);
        end else if ({32'd0, mag} >= ten_to(w) || k > w) begin
            // does not fit: dash then x fill
            text.push_back(CH_MINUS);
            for (int j = 1; j < w; j++) text.push_back(CH_X);
        end else begin
            rem = mag;
            for (int j = 0; j < w; j++) begin
                shown[j] = (rem != 0);
                digit[j] = int'(rem % 10);
                rem      = rem / 10;
            end
            text.push_back(neg ? CH_MINUS : CH_SPACE);
            for (int pos = w - 1; pos >= 0; pos--) begin
                if (k != 0 && pos == k - 1) text.push_back(CH_DOT);
                if (shown[pos])
                    text.push_back(CH_ZERO + CHAR_W'(digit[pos]));
                else if (pos <= k || zp)
                    text.push_back(CH_ZERO);
                else
                    text.push_back(CH_SPACE);
            end
        end
        foreach (text[i]) begin
            e.ch   = text[i];
            e.last = (i == text.size() - 1);
            pending_chars.push_back(e);
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        err_count++;
    endtask

    function automatic logic [IN_TDATA_W-1:0] make_word(input logic [31:0] value,
                                                        input int w, input int k,
                                                        input logic zp);
        return {7'd0, zp, 4'(k), 4'(w), value};
    endfunction

    // Random words: mostly fitting values, some boundary, some anything at all
    task automatic add_random_words(input int count);
        int          sel;
        int          w;
        int          k;
        logic        zp;
        logic        neg;
        logic [31:0] mag;
        logic [31:0] value;
        repeat (count) begin
            sel = $urandom_range(99);
            zp  = 1'($urandom_range(1));
            neg = 1'($urandom_range(1));
            w   = $urandom_range(FIELD_MAX, 1);
            if (sel < 70) begin
                k     = $urandom_range(w, 0);
                mag   = $urandom_range(32'(ten_to($urandom_range(w, 0))) - 1, 0);
                value = neg ? -mag : mag;
            end else if (sel < 80) begin
                // boundary of the field: largest fit and smallest overflow
                k     = $urandom_range(w, 0);
                mag   = 32'(ten_to(w)) - 32'($urandom_range(1));
                value = neg ? -mag : mag;
            end else if (sel < 90) begin
                k     = $urandom_range(FIELD_MAX, 0);
                value = $urandom;
            end else begin
                w     = $urandom_range(15);
                k     = $urandom_range(15);
                value = $urandom;
            end
            words_to_send.push_back(make_word(value, w, k, zp));
        end
    endtask

    task automatic add_directed_words();
        words_to_send.push_back(make_word(32'd0, 1, 0, 1'b0));
        words_to_send.push_back(make_word(32'd0, 9, 0, 1'b0));
        words_to_send.push_back(make_word(32'd0, 9, 9, 1'b0));
        words_to_send.push_back(make_word(32'd0, 9, 3, 1'b1));
        words_to_send.push_back(make_word(32'd123, 5, 2, 1'b0));
        words_to_send.push_back(make_word(-32'sd123, 5, 2, 1'b1));
        words_to_send.push_back(make_word(32'd7, 4, 1, 1'b0));
        words_to_send.push_back(make_word(32'd7, 4, 1, 1'b1));
        words_to_send.push_back(make_word(32'd999999999, 9, 0, 1'b0));
        words_to_send.push_back(make_word(-32'sd999999999, 9, 4, 1'b1));
        words_to_send.push_back(make_word(32'd1000000000, 9, 0, 1'b0));
        words_to_send.push_back(make_word(32'h7FFF_FFFF, 9, 2, 1'b0));
        // most negative value always overflows
        words_to_send.push_back(make_word(32'h8000_0000, 9, 0, 1'b1));
        words_to_send.push_back(make_word(32'h8000_0000, 1, 0, 1'b0));
        // point straight after the sign
        words_to_send.push_back(make_word(32'd5, 3, 3, 1'b0));
        words_to_send.push_back(make_word(-32'sd5, 3, 3, 1'b1));
        // more fraction digits than field width
        words_to_send.push_back(make_word(32'd5, 3, 4, 1'b0));
        words_to_send.push_back(make_word(32'd5, 9, 15, 1'b1));
        // width out of range
        words_to_send.push_back(make_word(32'd5, 0, 0, 1'b0));
        words_to_send.push_back(make_word(32'd5, 10, 0, 1'b0));
        words_to_send.push_back(make_word(32'hFFFF_FFFF, 15, 15, 1'b1));
        words_to_send.push_back(make_word(32'd9, 1, 0, 1'b0));
        words_to_send.push_back(make_word(32'd10, 1, 0, 1'b0));
        words_to_send.push_back(make_word(-32'sd9, 1, 1, 1'b1));
    endtask

    // Sender: hold a word until taken, then maybe idle, then the next word
    always @(negedge i_clk) begin : drive_input
        logic                  nxt_valid;
        logic [IN_TDATA_W-1:0] nxt_data;
        nxt_valid = src_valid;
        nxt_data  = src_data;
        if (i_rst_n && (!src_valid || word_taken)) begin
            nxt_valid = 1'b0;
            if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt_valid = 1'b1;
                nxt_data  = words_to_send.pop_front();
            end
        end
        src_valid <= nxt_valid;
        src_data  <= nxt_data;
    end

    // Receiver back-pressure
    always @(negedge i_clk) begin
        sink_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Input acceptance and output checking, sampled at the rising edge
    always @(posedge i_clk) begin : watch_ports
        t_char_exp e;
        word_taken <= i_rst_n && src_valid && o_s_axis_tready;
        if (i_rst_n && src_valid && o_s_axis_tready) begin
            predict_string(src_data);
            values_formatted++;
        end
        if (i_rst_n && o_m_axis_tvalid && sink_ready) begin
            if (pending_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected word char=%02h last=%0b",
                                          o_m_axis_tdata, o_m_axis_tlast));
            end else begin
                e = pending_chars.pop_front();
                chars_checked++;
                if (o_m_axis_tdata !== e.ch)
                    report_mismatch($sformatf("char %02h, expected %02h",
                                              o_m_axis_tdata, e.ch));
                if (o_m_axis_tlast !== e.last)
                    report_mismatch($sformatf("tlast %0b, expected %0b on char %02h",
                                              o_m_axis_tlast, e.last, e.ch));
            end
        end
    end

    // Stimulus phases and end of run
    initial begin
        int send_pct [4];
        int recv_pct [4];
        send_pct = '{0, 64, 0, 15};
        recv_pct = '{0, 0, 64, 15};
        i_rst_n          = 1'b0;
        src_valid        = 1'b0;
        src_data         = '0;
        sink_ready       = 1'b0;
        word_taken       = 1'b0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        err_count        = 0;
        values_formatted = 0;
        chars_checked    = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = send_pct[ph];
            recv_stall_pct = recv_pct[ph];
            if (ph == 0) add_directed_words();
            add_random_words(27);
            // sender holds off until every string has come out
            while (words_to_send.size() != 0 || src_valid || pending_chars.size() != 0)
                @(posedge i_clk);
        end

        // let any stray word show itself
        recv_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Formatted %0d values into %0d checked characters across four idling phases.",
                 values_formatted, chars_checked);
        if (err_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("Timeout with %0d characters outstanding", pending_chars.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/sfwdf_pkg.sv
sv/sfwdf_front.sv
sv/sfwdf_digit.sv
sv/sfwdf_ser.sv
sv/signed_fixed_width_decimal_formatter.sv
tb/tb_top.sv
